// ===== rtl/dtt_pkg.sv =====
package dtt_pkg;

   localparam int TIME_W      = 48;
   localparam int IVL_W       = 40;
   localparam int GEN_W       = 8;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = 5;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_RSVD   = 2'd3;

   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_CANCELLED = 3'd2;
   localparam logic [2:0] ST_MISSED    = 3'd3;
   localparam logic [2:0] ST_EXPIRED   = 3'd4;
   localparam logic [2:0] ST_NONE      = 3'd5;

   typedef struct packed {
      logic [1:0]        operation;
      logic [TIME_W-1:0] time_value;
      logic [IVL_W-1:0]  repeat_interval;
      logic [3:0]        slot_id;
      logic [GEN_W-1:0]  slot_generation;
   } dtt_req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [3:0]        result_slot;
      logic [GEN_W-1:0]  result_generation;
      logic              rearmed;
      logic              last_of_run;
      logic [TIME_W-1:0] next_deadline;
      logic              any_pending;
   } dtt_rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [IVL_W-1:0]  interval;
      logic [GEN_W-1:0]  gen;
   } slot_word_type;

   typedef struct packed {
      logic clear;
      logic take;
      logic limit_mode;
   } min_ctrl_type;

endpackage

// ===== rtl/dtt_min_unit.sv =====
module dtt_min_unit #(
   parameter int IDX_W = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dtt_pkg::min_ctrl_type      ctrl,
   input  logic [dtt_pkg::TIME_W-1:0] cand_key,
   input  logic [IDX_W-1:0]           cand_idx,
   input  logic [dtt_pkg::TIME_W-1:0] limit,
   output logic                       below,
   output logic [dtt_pkg::TIME_W-1:0] best_key,
   output logic [IDX_W-1:0]           best_idx,
   output logic                       found
);
   import dtt_pkg::*;

   logic [TIME_W-1:0] best_key_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              found_ff;
   logic [TIME_W-1:0] opa;
   logic [TIME_W-1:0] opb;

   // One comparator serves both jobs: limit < candidate when testing against the
   // current time, candidate < best when tracking the minimum.
   assign opa   = ctrl.limit_mode ? limit : cand_key;
   assign opb   = ctrl.limit_mode ? cand_key : best_key_ff;
   assign below = opa < opb;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (ctrl.take && !ctrl.limit_mode && (!found_ff || below)) begin
         found_ff    <= 1'b1;
         best_key_ff <= cand_key;
         best_idx_ff <= cand_idx;
      end
   end

   assign best_key = best_key_ff;
   assign best_idx = best_idx_ff;
   assign found    = found_ff;

endmodule

// ===== rtl/deadline_timer_table_core.sv =====
// Channel | Ports                          | Direction | Transfer when
// --------+--------------------------------+-----------+-----------------------
// request | req_valid, req_ready, req_data | in        | req_valid & req_ready
// result  | rsp_valid, rsp_ready, rsp_data | out       | rsp_valid & rsp_ready
//
// One request is worked on at a time; req_ready is high only while idle.
// A tick that expires timers is paced by the single read port of the slot
// memory and by the one shared comparator.
// Reset clears the valid and generation marks at once; there is no clearing pass.
// A result waiting in the output register does not stop the next request.
module deadline_timer_table_core #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dtt_pkg::dtt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dtt_pkg::dtt_rsp_type rsp_data
);
   import dtt_pkg::*;

   localparam int IDX_W = $clog2(TIMER_SLOTS);
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_APPLY,
      S_DUE,
      S_SUM,
      S_PICK,
      S_EMIT
   } state_type;

   function automatic dtt_rsp_type make_rsp(input logic [2:0] status,
                                             input logic [3:0] slot,
                                             input logic [GEN_W-1:0] gen,
                                             input logic rearm,
                                             input logic last);
      dtt_rsp_type r;
      r                   = '0;
      r.status            = status;
      r.result_slot       = slot;
      r.result_generation = gen;
      r.rearmed           = rearm;
      r.last_of_run       = last;
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [TIME_W-1:0]    tv_ff, tv_in;
   logic [IVL_W-1:0]     iv_ff, iv_in;
   logic [3:0]           sid_ff, sid_in;
   logic [GEN_W-1:0]     sgen_ff, sgen_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [TIMER_SLOTS-1:0] written_ff, written_in;
   logic [TIMER_SLOTS-1:0] due_ff, due_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 s1_v_ff, s1_v_in;
   logic [IDX_W-1:0]     s1_idx_ff, s1_idx_in;
   logic                 s2_v_ff, s2_v_in;
   logic [IDX_W-1:0]     s2_idx_ff, s2_idx_in;
   logic [TIME_W-1:0]    key_ff, key_in;
   logic                 incl_ff, incl_in;
   dtt_rsp_type          res_ff, res_in;
   logic [RES_CNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]    sum_dl_ff, sum_dl_in;
   logic                 sum_any_ff, sum_any_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dtt_rsp_type          rsp_data_ff, rsp_data_in;

   slot_word_type        slot_mem_ff [TIMER_SLOTS];
   slot_word_type        rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   slot_word_type        wr_word;

   logic                 free_found;
   logic [IDX_W-1:0]     free_idx;
   logic [TIME_W:0]      sum_wide;
   logic [TIME_W-1:0]    sat_dl;
   logic [GEN_W-1:0]     rd_gen;
   logic                 scanning;
   logic                 issuing;
   logic                 scan_done;
   logic                 out_free;
   logic [TIMER_SLOTS-1:0] due_left;
   logic                 incl1;
   logic [TIME_W-1:0]    key1;
   min_ctrl_type         min_ctrl;
   logic                 below;
   logic [TIME_W-1:0]    best_key;
   logic [IDX_W-1:0]     best_idx;
   logic                 best_found;

   // Slot memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_word;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // The re-arm adder: re-armed deadline, saturating at the top of the time range.
   assign sum_wide = {1'b0, tv_ff} + (TIME_W + 1)'(rd_data_ff.interval);
   assign sat_dl   = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
   assign rd_gen   = written_ff[addr_ff] ? rd_data_ff.gen : '0;

   assign scanning  = (state_ff == S_DUE) || (state_ff == S_SUM) || (state_ff == S_PICK);
   assign issuing   = scanning && (cnt_ff < CNT_W'(TIMER_SLOTS));
   assign scan_done = scanning && !issuing && !s1_v_ff && !s2_v_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_addr   = (state_ff == S_FETCH) ? addr_ff : cnt_ff[IDX_W-1:0];

   // First stage of a scan: decide whether the slot just read takes part, and its key.
   always_comb begin
      incl1 = valid_ff[s1_idx_ff];
      key1  = rd_data_ff.deadline;
      case (state_ff)
         S_SUM: begin
            if (due_ff[s1_idx_ff]) begin
               incl1 = rd_data_ff.interval != '0;
               key1  = sat_dl;
            end
         end
         S_PICK: begin
            incl1 = due_ff[s1_idx_ff];
         end
         default: begin
            incl1 = valid_ff[s1_idx_ff];
         end
      endcase
   end

   assign min_ctrl.clear      = scanning && (cnt_ff == '0);
   assign min_ctrl.take       = s2_v_ff && incl_ff;
   assign min_ctrl.limit_mode = state_ff == S_DUE;

   dtt_min_unit #(
      .IDX_W(IDX_W)
   ) u_min (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (min_ctrl),
      .cand_key(key_ff),
      .cand_idx(s2_idx_ff),
      .limit   (tv_ff),
      .below   (below),
      .best_key(best_key),
      .best_idx(best_idx),
      .found   (best_found)
   );

   always_comb begin
      due_left          = due_ff;
      due_left[addr_ff] = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tv_in        = tv_ff;
      iv_in        = iv_ff;
      sid_in       = sid_ff;
      sgen_in      = sgen_ff;
      addr_in      = addr_ff;
      valid_in     = valid_ff;
      written_in   = written_ff;
      due_in       = due_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      sum_dl_in    = sum_dl_ff;
      sum_any_in   = sum_any_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      s1_v_in      = issuing;
      s1_idx_in    = cnt_ff[IDX_W-1:0];
      s2_v_in      = s1_v_ff;
      s2_idx_in    = s1_idx_ff;
      key_in       = key1;
      incl_in      = incl1;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_word      = rd_data_ff;

      if (issuing) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if ((state_ff == S_DUE) && min_ctrl.take && !below) begin
         due_in[s2_idx_ff] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               tv_in    = req_data.time_value;
               iv_in    = req_data.repeat_interval;
               sid_in   = req_data.slot_id;
               sgen_in  = req_data.slot_generation;
               due_in   = '0;
               count_in = '0;
               cnt_in   = '0;
               case (req_data.operation)
                  OP_ADD: begin
                     if (free_found) begin
                        addr_in  = free_idx;
                        state_in = S_FETCH;
                     end else begin
                        res_in   = make_rsp(ST_FULL, 4'd0, '0, 1'b0, 1'b1);
                        state_in = S_SUM;
                     end
                  end
                  OP_CANCEL: begin
                     if (32'(req_data.slot_id) < 32'(TIMER_SLOTS)) begin
                        addr_in  = IDX_W'(req_data.slot_id);
                        state_in = S_FETCH;
                     end else begin
                        res_in   = make_rsp(ST_MISSED, req_data.slot_id,
                                            req_data.slot_generation, 1'b0, 1'b1);
                        state_in = S_SUM;
                     end
                  end
                  OP_TICK: begin
                     state_in = S_DUE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cnt_in = '0;
            case (op_ff)
               OP_ADD: begin
                  wr_en               = 1'b1;
                  wr_word.deadline    = tv_ff;
                  wr_word.interval    = iv_ff;
                  wr_word.gen         = rd_gen + 1'b1;
                  valid_in[addr_ff]   = 1'b1;
                  written_in[addr_ff] = 1'b1;
                  res_in   = make_rsp(ST_ADDED, 4'(addr_ff), rd_gen + 1'b1, 1'b0, 1'b1);
                  state_in = S_SUM;
               end
               OP_CANCEL: begin
                  if (valid_ff[addr_ff] && (rd_gen == sgen_ff)) begin
                     valid_in[addr_ff] = 1'b0;
                     res_in = make_rsp(ST_CANCELLED, sid_ff, sgen_ff, 1'b0, 1'b1);
                  end else begin
                     res_in = make_rsp(ST_MISSED, sid_ff, sgen_ff, 1'b0, 1'b1);
                  end
                  state_in = S_SUM;
               end
               default: begin
                  // Expiry of the picked timer: re-arm it or free it.
                  due_in[addr_ff] = 1'b0;
                  if (rd_data_ff.interval != '0) begin
                     wr_en            = 1'b1;
                     wr_word.deadline = sat_dl;
                  end else begin
                     valid_in[addr_ff] = 1'b0;
                  end
                  if (count_ff < RES_CNT_W'(MAX_RESULTS)) begin
                     res_in = make_rsp(ST_EXPIRED, 4'(addr_ff), rd_gen,
                                       rd_data_ff.interval != '0,
                                       (due_left == '0) ||
                                       (count_ff == RES_CNT_W'(MAX_RESULTS - 1)));
                     count_in = count_ff + 1'b1;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_PICK;
                  end
               end
            endcase
         end
         S_DUE: begin
            if (scan_done) begin
               cnt_in   = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (scan_done) begin
               sum_dl_in  = best_found ? best_key : '0;
               sum_any_in = best_found;
               cnt_in     = '0;
               state_in   = (op_ff == OP_TICK) ? S_PICK : S_EMIT;
            end
         end
         S_PICK: begin
            if (scan_done) begin
               if (best_found) begin
                  addr_in  = best_idx;
                  state_in = S_FETCH;
               end else if (count_ff == '0) begin
                  res_in   = make_rsp(ST_NONE, 4'd0, '0, 1'b0, 1'b1);
                  state_in = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in               = res_ff;
               rsp_data_in.next_deadline = sum_dl_ff;
               rsp_data_in.any_pending   = sum_any_ff;
               if ((op_ff == OP_TICK) && (due_ff != '0)) begin
                  cnt_in   = '0;
                  state_in = S_PICK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         written_ff   <= '0;
         due_ff       <= '0;
         cnt_ff       <= '0;
         count_ff     <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         written_ff   <= written_in;
         due_ff       <= due_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      tv_ff       <= tv_in;
      iv_ff       <= iv_in;
      sid_ff      <= sid_in;
      sgen_ff     <= sgen_in;
      addr_ff     <= addr_in;
      s1_idx_ff   <= s1_idx_in;
      s2_idx_ff   <= s2_idx_in;
      key_ff      <= key_in;
      incl_ff     <= incl_in;
      res_ff      <= res_in;
      sum_dl_ff   <= sum_dl_in;
      sum_any_ff  <= sum_any_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/dtt_checker.sv =====
module dtt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input dtt_pkg::dtt_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dtt_pkg::dtt_rsp_type rsp_data
);
   import dtt_pkg::*;

   // A stalled result must hold until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // Any operation other than the unused code keeps the block busy afterwards.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.operation != OP_RSVD) |=> !req_ready)
      else $error("request taken while the previous one is in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.any_pending |-> rsp_data.next_deadline == '0)
      else $error("next deadline reported with no pending timer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_EXPIRED) |->
         rsp_data.last_of_run && !rsp_data.rearmed)
      else $error("single result not marked last, or re-arm flag on a non-expiry");

endmodule

bind deadline_timer_table_core dtt_checker u_dtt_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

// ===== tb/tb_deadline_timer_table_core.sv =====
module tb_deadline_timer_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   import dtt_pkg::*;

   localparam int TIMER_SLOTS  = 16;
   localparam int RANDOM_ITEMS = 290;
   localparam int REUSE_PAIRS  = 30;
   localparam int IDLE_PCT     = 31;
   localparam int TAIL_CYCLES  = 450;
   localparam int STALL_LIMIT  = 4000;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [IVL_W-1:0]  IVL_MAX  = '1;

   // Mirror of the timer slots; works out the results of every accepted request.
   class timer_table_scoreboard;
      bit                slot_live[TIMER_SLOTS];
      logic [TIME_W-1:0] slot_due[TIMER_SLOTS];
      logic [IVL_W-1:0]  slot_period[TIMER_SLOTS];
      logic [GEN_W-1:0]  slot_gen[TIMER_SLOTS];
      dtt_rsp_type       expected_q[$];
      int                last_slot;
      logic [GEN_W-1:0]  last_gen;
      int                errors;

      function new();
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            slot_live[i]   = 1'b0;
            slot_due[i]    = '0;
            slot_period[i] = '0;
            slot_gen[i]    = '0;
         end
         last_slot = -1;
         last_gen  = '0;
         errors    = 0;
      endfunction

      function void note_input(dtt_req_type r);
         dtt_rsp_type       batch[$];
         dtt_rsp_type       e;
         bit                due[TIMER_SLOTS];
         int                pick;
         logic [TIME_W:0]   sum;
         logic [TIME_W-1:0] best;
         bit                any;
         if (r.operation == OP_RSVD) return;
         e = '0;
         e.last_of_run = 1'b1;
         case (r.operation)
            OP_ADD: begin
               pick = -1;
               for (int i = 0; i < TIMER_SLOTS; i++)
                  if (!slot_live[i] && pick < 0) pick = i;
               if (pick >= 0) begin
                  slot_live[pick]   = 1'b1;
                  slot_gen[pick]    = slot_gen[pick] + 1'b1;
                  slot_due[pick]    = r.time_value;
                  slot_period[pick] = r.repeat_interval;
                  e.status            = ST_ADDED;
                  e.result_slot       = 4'(pick);
                  e.result_generation = slot_gen[pick];
                  last_slot = pick;
                  last_gen  = slot_gen[pick];
               end else begin
                  e.status = ST_FULL;
               end
               batch.insert(batch.size(), e);
            end
            OP_CANCEL: begin
               e.result_slot       = r.slot_id;
               e.result_generation = r.slot_generation;
               if (slot_live[r.slot_id] && slot_gen[r.slot_id] == r.slot_generation) begin
                  slot_live[r.slot_id] = 1'b0;
                  e.status = ST_CANCELLED;
               end else begin
                  e.status = ST_MISSED;
               end
               batch.insert(batch.size(), e);
            end
            default: begin
               for (int i = 0; i < TIMER_SLOTS; i++)
                  due[i] = slot_live[i] && slot_due[i] <= r.time_value;
               // Due slots leave in deadline order, ties to the lower index.
               for (int n = 0; n < TIMER_SLOTS; n++) begin
                  pick = -1;
                  for (int i = 0; i < TIMER_SLOTS; i++)
                     if (due[i] && (pick < 0 || slot_due[i] < slot_due[pick])) pick = i;
                  if (pick < 0) break;
                  due[pick] = 1'b0;
                  e = '0;
                  e.status            = ST_EXPIRED;
                  e.result_slot       = 4'(pick);
                  e.result_generation = slot_gen[pick];
                  e.rearmed           = slot_period[pick] != '0;
                  if (e.rearmed) begin
                     sum = {1'b0, r.time_value} + {{(TIME_W + 1 - IVL_W){1'b0}}, slot_period[pick]};
                     slot_due[pick] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                  end else begin
                     slot_live[pick] = 1'b0;
                  end
                  if (batch.size() < MAX_RESULTS) batch.insert(batch.size(), e);
               end
               if (batch.size() == 0) begin
                  e = '0;
                  e.status      = ST_NONE;
                  e.last_of_run = 1'b1;
               end else begin
                  e = batch.pop_back();
                  e.last_of_run = 1'b1;
               end
               batch.insert(batch.size(), e);
            end
         endcase
         best = '0;
         any  = 1'b0;
         for (int i = 0; i < TIMER_SLOTS; i++)
            if (slot_live[i] && (!any || slot_due[i] < best)) begin
               best = slot_due[i];
               any  = 1'b1;
            end
         while (batch.size() != 0) begin
            e = batch.pop_front();
            e.next_deadline = best;
            e.any_pending   = any;
            expected_q.insert(expected_q.size(), e);
         end
      endfunction

      function void compare_field(string name, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(dtt_rsp_type got);
         dtt_rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing outstanding: %0h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", TIME_W'(want.status), TIME_W'(got.status));
         compare_field("result_slot", TIME_W'(want.result_slot), TIME_W'(got.result_slot));
         compare_field("result_generation", TIME_W'(want.result_generation),
                       TIME_W'(got.result_generation));
         compare_field("rearmed", TIME_W'(want.rearmed), TIME_W'(got.rearmed));
         compare_field("last_of_run", TIME_W'(want.last_of_run), TIME_W'(got.last_of_run));
         compare_field("next_deadline", want.next_deadline, got.next_deadline);
         compare_field("any_pending", TIME_W'(want.any_pending), TIME_W'(got.any_pending));
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dtt_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dtt_rsp_type rsp_data;

   bit                    calm = 1'b0;
   int                    stall_cycles = 0;
   logic [TIME_W-1:0]     now_us = '0;
   timer_table_scoreboard sb = new();

   deadline_timer_table_core #(
      .TIMER_SLOTS(TIMER_SLOTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[deadline_timer_table_core] ERROR");
         $finish;
      end
   end

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[TIME_W-1:0];
   endfunction

   function automatic logic [IVL_W-1:0] rand_ivl();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[IVL_W-1:0];
   endfunction

   function automatic dtt_req_type make_req(logic [1:0] op, logic [TIME_W-1:0] tv,
                                            logic [IVL_W-1:0] iv, logic [3:0] sid,
                                            logic [GEN_W-1:0] sgen);
      dtt_req_type r;
      r.operation       = op;
      r.time_value      = tv;
      r.repeat_interval = iv;
      r.slot_id         = sid;
      r.slot_generation = sgen;
      return r;
   endfunction

   // Called just after a rising edge; returns at the edge of the transfer.
   task automatic send_req(dtt_req_type r);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_input(r);
   endtask

   task automatic send_add();
      logic [TIME_W-1:0] tv;
      logic [IVL_W-1:0]  iv;
      int                roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)      tv = now_us + TIME_W'($urandom_range(0, 2000));
      else if (roll < 90) tv = rand_time();
      else if (roll < 95) tv = TIME_MAX;
      else                tv = now_us;
      roll = $urandom_range(0, 99);
      if (roll < 40)      iv = '0;
      else if (roll < 80) iv = IVL_W'($urandom_range(1, 1500));
      else if (roll < 93) iv = rand_ivl();
      else                iv = IVL_MAX;
      send_req(make_req(OP_ADD, tv, iv, 4'($urandom_range(0, 15)),
                        GEN_W'($urandom_range(0, 255))));
   endtask

   task automatic send_cancel();
      int               live[$];
      int               roll;
      int               s;
      logic [GEN_W-1:0] g;
      for (int i = 0; i < TIMER_SLOTS; i++)
         if (sb.slot_live[i]) live.insert(live.size(), i);
      roll = $urandom_range(0, 99);
      if (live.size() != 0 && roll < 85) begin
         s = live[$urandom_range(0, live.size() - 1)];
         g = sb.slot_gen[s];
         if (roll >= 70) g = g + GEN_W'($urandom_range(1, 255));
      end else begin
         s = $urandom_range(0, 15);
         g = GEN_W'($urandom_range(0, 255));
      end
      send_req(make_req(OP_CANCEL, rand_time(), rand_ivl(), 4'(s), g));
   endtask

   initial begin
      dtt_req_type r;
      int          roll;
      bit          fill_mode;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty table, extremes, equal deadlines, saturating
      // re-arm, reserved code and finally a full table.
      send_req(make_req(OP_TICK, '0, '0, '0, '0));
      send_req(make_req(OP_CANCEL, '0, '0, 4'd15, 8'd255));
      send_req(make_req(OP_ADD, '0, '0, '0, '0));
      send_req(make_req(OP_ADD, TIME_MAX, IVL_MAX, '0, '0));
      send_req(make_req(OP_ADD, 48'd5, 40'd1, '0, '0));
      send_req(make_req(OP_ADD, 48'd5, '0, '0, '0));
      send_req(make_req(OP_CANCEL, '0, '0, 4'd0, 8'd2));
      send_req(make_req(OP_TICK, 48'd5, '0, '0, '0));
      // The re-armed deadline saturates at the current time and must not fire twice.
      send_req(make_req(OP_TICK, TIME_MAX, '0, '0, '0));
      r = make_req(OP_RSVD, rand_time(), rand_ivl(), 4'($urandom_range(0, 15)),
                   GEN_W'($urandom_range(0, 255)));
      send_req(r);
      for (int k = 0; k < 14; k++)
         send_req(make_req(OP_ADD, TIME_W'(100 + k % 3), (k % 2) ? IVL_W'(k) : '0,
                           '0, '0));
      send_req(make_req(OP_ADD, '0, '0, '0, '0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm      = (n >= 150 && n < 230);
         fill_mode = ((n / 40) % 2) == 0;
         roll      = $urandom_range(0, 99);
         if (roll < 3) begin
            r = make_req(2'($urandom_range(0, 3)), rand_time(), rand_ivl(),
                         4'($urandom_range(0, 15)), GEN_W'($urandom_range(0, 255)));
            send_req(r);
         end else if (roll < (fill_mode ? 60 : 25)) begin
            send_add();
         end else if (roll < (fill_mode ? 78 : 50)) begin
            send_cancel();
         end else begin
            now_us = now_us + TIME_W'($urandom_range(0, 1200));
            r = make_req(OP_TICK, ($urandom_range(0, 99) < 5) ? rand_time() : now_us,
                         rand_ivl(), 4'($urandom_range(0, 15)),
                         GEN_W'($urandom_range(0, 255)));
            send_req(r);
         end
      end
      calm = 1'b0;

      // Add and cancel pairs that keep reusing the lowest free slot.
      if (sb.slot_live[0])
         send_req(make_req(OP_CANCEL, '0, '0, 4'd0, sb.slot_gen[0]));
      for (int n = 0; n < REUSE_PAIRS; n++) begin
         send_add();
         send_req(make_req(OP_CANCEL, rand_time(), rand_ivl(), 4'(sb.last_slot),
                           sb.last_gen));
      end
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("[deadline_timer_table_core] OK");
      else
         $display("[deadline_timer_table_core] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dtt_pkg.sv
rtl/dtt_min_unit.sv
rtl/deadline_timer_table_core.sv
rtl/dtt_checker.sv
tb/tb_deadline_timer_table_core.sv
